// ----- hw/rtl/char_lcd_nibble_sequencer_macros.svh -----
// Assertion macros shared by the LCD nibble sequencer RTL.
// Depends on nothing; the asserting files take it in by include.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// Concurrent check on a named clock and active-low reset
`define CHLCD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check on the house clock and reset names
`define CHLCD_ASSERT(label, prop, msg) \
    `CHLCD_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define CHLCD_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define CHLCD_ASSERT(label, prop, msg)
`endif

`endif

// ----- hw/rtl/chlcd_pkg.sv -----
// Types, constants and the microcode table of the LCD nibble sequencer.
// Depends on nothing; used by the RTL modules and the bench.
`timescale 1ns / 1ps

package chlcd_pkg;

    // Operation codes
    localparam logic [2:0] OP_CMD    = 3'd0;
    localparam logic [2:0] OP_DATA   = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_INIT   = 3'd4;

    // Expander port bits
    localparam logic [7:0] BIT_RS = 8'h01;
    localparam logic [7:0] BIT_EN = 8'h04;
    localparam logic [7:0] BIT_BL = 8'h08;

    // LCD command bytes and cursor bases
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;
    localparam logic [1:0] CLEAR_WAIT = 2'd2;

    // Microcode layout
    localparam int         PC_W       = 6;
    localparam logic [5:0] BYTE_ENTRY = 6'd0;
    localparam logic [5:0] INIT_ENTRY = 6'd6;
    localparam logic [5:0] LAST_STEP  = 6'd47;
    localparam logic [5:0] POWER_MS   = 6'd50;

    // One control word
    typedef struct packed {
        logic       use_const;  // nibble from the word, not the operand
        logic       lo;         // low nibble of the operand
        logic [3:0] nib;
        logic       en;
        logic [5:0] pre;
        logic [2:0] post;
        logic       add_extra;  // add the operation's extra wait to post
        logic       last;
    } t_cw;

    // One result beat
    typedef struct packed {
        logic [5:0] pre_delay_ms;
        logic [7:0] port_byte;
        logic [2:0] post_delay_ms;
        logic       last;
    } t_beat;

    // Step of the shared byte routine
    function automatic t_cw f_byt(input logic lo, input logic en, input logic [2:0] post,
                                  input logic add_extra, input logic last);
        t_cw w;
        w.use_const = 1'b0;
        w.lo        = lo;
        w.nib       = 4'h0;
        w.en        = en;
        w.pre       = 6'd0;
        w.post      = post;
        w.add_extra = add_extra;
        w.last      = last;
        return w;
    endfunction

    // Step of the initialisation program, constant nibble
    function automatic t_cw f_ini(input logic [3:0] nib, input logic en, input logic [5:0] pre,
                                  input logic [2:0] post, input logic last);
        t_cw w;
        w.use_const = 1'b1;
        w.lo        = 1'b0;
        w.nib       = nib;
        w.en        = en;
        w.pre       = pre;
        w.post      = post;
        w.add_extra = 1'b0;
        w.last      = last;
        return w;
    endfunction

    // Microcode ROM: byte routine at 0, initialisation at 6
    function automatic t_cw f_rom(input logic [5:0] pc);
        t_cw w;
        case (pc)
            // byte: high nibble then low nibble
            6'd0:  w = f_byt(1'b0, 1'b0, 3'd0, 1'b0, 1'b0);
            6'd1:  w = f_byt(1'b0, 1'b1, 3'd1, 1'b0, 1'b0);
            6'd2:  w = f_byt(1'b0, 1'b0, 3'd1, 1'b0, 1'b0);
            6'd3:  w = f_byt(1'b1, 1'b0, 3'd0, 1'b0, 1'b0);
            6'd4:  w = f_byt(1'b1, 1'b1, 3'd1, 1'b0, 1'b0);
            6'd5:  w = f_byt(1'b1, 1'b0, 3'd1, 1'b1, 1'b1);
            // wake-up nibbles
            6'd6:  w = f_ini(4'h3, 1'b0, POWER_MS, 3'd0, 1'b0);
            6'd7:  w = f_ini(4'h3, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd8:  w = f_ini(4'h3, 1'b0, 6'd0, 3'd6, 1'b0);
            6'd9:  w = f_ini(4'h3, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd10: w = f_ini(4'h3, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd11: w = f_ini(4'h3, 1'b0, 6'd0, 3'd2, 1'b0);
            6'd12: w = f_ini(4'h3, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd13: w = f_ini(4'h3, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd14: w = f_ini(4'h3, 1'b0, 6'd0, 3'd1, 1'b0);
            // switch to 4-bit
            6'd15: w = f_ini(4'h2, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd16: w = f_ini(4'h2, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd17: w = f_ini(4'h2, 1'b0, 6'd0, 3'd1, 1'b0);
            // function set, two lines
            6'd18: w = f_ini(4'h2, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd19: w = f_ini(4'h2, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd20: w = f_ini(4'h2, 1'b0, 6'd0, 3'd1, 1'b0);
            6'd21: w = f_ini(4'h8, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd22: w = f_ini(4'h8, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd23: w = f_ini(4'h8, 1'b0, 6'd0, 3'd1, 1'b0);
            // display off
            6'd24: w = f_ini(4'h0, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd25: w = f_ini(4'h0, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd26: w = f_ini(4'h0, 1'b0, 6'd0, 3'd1, 1'b0);
            6'd27: w = f_ini(4'h8, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd28: w = f_ini(4'h8, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd29: w = f_ini(4'h8, 1'b0, 6'd0, 3'd1, 1'b0);
            // clear, with the long wait
            6'd30: w = f_ini(4'h0, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd31: w = f_ini(4'h0, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd32: w = f_ini(4'h0, 1'b0, 6'd0, 3'd1, 1'b0);
            6'd33: w = f_ini(4'h1, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd34: w = f_ini(4'h1, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd35: w = f_ini(4'h1, 1'b0, 6'd0, 3'd3, 1'b0);
            // entry mode
            6'd36: w = f_ini(4'h0, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd37: w = f_ini(4'h0, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd38: w = f_ini(4'h0, 1'b0, 6'd0, 3'd1, 1'b0);
            6'd39: w = f_ini(4'h6, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd40: w = f_ini(4'h6, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd41: w = f_ini(4'h6, 1'b0, 6'd0, 3'd1, 1'b0);
            // display on
            6'd42: w = f_ini(4'h0, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd43: w = f_ini(4'h0, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd44: w = f_ini(4'h0, 1'b0, 6'd0, 3'd1, 1'b0);
            6'd45: w = f_ini(4'hC, 1'b0, 6'd0, 3'd0, 1'b0);
            6'd46: w = f_ini(4'hC, 1'b1, 6'd0, 3'd1, 1'b0);
            6'd47: w = f_ini(4'hC, 1'b0, 6'd0, 3'd1, 1'b1);
            // unused addresses halt
            default: w = f_ini(4'h0, 1'b0, 6'd0, 3'd0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/chlcd_ifs.sv -----
// Valid/ready channel interfaces: LCD operations in, port-write beats out.
// Depends on nothing.
`timescale 1ns / 1ps

// Operation channel
interface chlcd_op_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] value;
    logic       row;
    logic [5:0] column;

    modport source (output valid, output op, output value, output row, output column,
                    input ready);
    modport sink   (input valid, input op, input value, input row, input column,
                    output ready);
endinterface

// Port-write result channel
interface chlcd_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] pre_delay_ms;
    logic [7:0] port_byte;
    logic [2:0] post_delay_ms;
    logic       last;

    modport source (output valid, output pre_delay_ms, output port_byte,
                    output post_delay_ms, output last, input ready);
    modport sink   (input valid, input pre_delay_ms, input port_byte,
                    input post_delay_ms, input last, output ready);
endinterface

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
// Top level of the character LCD nibble sequencer (4-bit mode over a port expander).
// Depends on chlcd_pkg, chlcd_ifs, chlcd_out_stage and the assertion macro header.
// The first port write is registered in the output stage once the op is taken and the stage has space.
// One write per cycle from a microcode step counter while the output stage has space;
//   ops 0-3 run 6 steps, initialise 42, and the next op is taken as the final step goes out.
// Reset: synchronous, active low; clears the sequencer and the output valid, no stores.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_macros.svh"

module char_lcd_nibble_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    chlcd_op_if.sink     i_op,
    chlcd_res_if.source  o_res
);

    logic                          r_busy;
    logic                          n_busy;
    logic [chlcd_pkg::PC_W-1:0]    r_pc;
    logic [chlcd_pkg::PC_W-1:0]    n_pc;
    logic [7:0]                    r_byte;
    logic [7:0]                    n_byte;
    logic                          r_rs;
    logic [1:0]                    r_extra;

    chlcd_pkg::t_cw                w_cw;
    chlcd_pkg::t_beat              w_beat;
    logic                          w_space;
    logic                          w_fire;
    logic                          w_done;
    logic                          w_acc;
    logic                          w_known;
    logic [3:0]                    w_nib;
    logic                          w_rs;
    logic [7:0]                    w_cursor;

    // Control word of the current step
    assign w_cw   = chlcd_pkg::f_rom(r_pc);
    assign w_fire = r_busy && w_space;
    assign w_done = w_fire && w_cw.last;

    // Take an operation when idle or as the final step goes out
    assign i_op.ready = !r_busy || w_done;
    assign w_acc      = i_op.valid && i_op.ready;
    assign w_known    = (i_op.op <= chlcd_pkg::OP_INIT);

    // Set-cursor address
    assign w_cursor = (i_op.row ? chlcd_pkg::ROW1_BASE : chlcd_pkg::ROW0_BASE)
                      + {2'b00, i_op.column};

    // Operand byte for the byte routine
    always_comb begin
        case (i_op.op)
            chlcd_pkg::OP_CMD:    n_byte = i_op.value;
            chlcd_pkg::OP_DATA:   n_byte = i_op.value;
            chlcd_pkg::OP_CURSOR: n_byte = w_cursor;
            chlcd_pkg::OP_CLEAR:  n_byte = chlcd_pkg::CMD_CLEAR;
            default:              n_byte = 8'h00;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (w_acc) begin
            n_busy = w_known;
            n_pc   = (i_op.op == chlcd_pkg::OP_INIT) ? chlcd_pkg::INIT_ENTRY
                                                     : chlcd_pkg::BYTE_ENTRY;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (w_fire) begin
            n_pc = r_pc + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= chlcd_pkg::BYTE_ENTRY;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    // Operand registers, loaded on acceptance
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_byte  <= n_byte;
            r_rs    <= (i_op.op == chlcd_pkg::OP_DATA);
            r_extra <= (i_op.op == chlcd_pkg::OP_CLEAR) ? chlcd_pkg::CLEAR_WAIT : 2'd0;
        end
    end

    // Datapath: nibble select and port byte assembly
    assign w_nib = w_cw.use_const ? w_cw.nib : (w_cw.lo ? r_byte[3:0] : r_byte[7:4]);
    assign w_rs  = !w_cw.use_const && r_rs;

    always_comb begin
        w_beat.pre_delay_ms  = w_cw.pre;
        w_beat.port_byte     = {w_nib, 4'h0} | chlcd_pkg::BIT_BL
                               | (w_cw.en ? chlcd_pkg::BIT_EN : 8'h00)
                               | (w_rs ? chlcd_pkg::BIT_RS : 8'h00);
        w_beat.post_delay_ms = w_cw.post + (w_cw.add_extra ? {1'b0, r_extra} : 3'd0);
        w_beat.last          = w_cw.last;
    end

    chlcd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire),
        .i_beat  (w_beat),
        .o_space (w_space),
        .o_res   (o_res)
    );

    `CHLCD_ASSERT(a_pc_in_rom, r_busy |-> (r_pc <= chlcd_pkg::LAST_STEP), "step past program end")
    `CHLCD_ASSERT(a_take_only_at_end, w_acc && r_busy |-> w_done, "op taken mid-program")
    `CHLCD_ASSERT(a_done_idles, w_done && !w_acc |=> !r_busy, "sequencer still busy after end")

endmodule

// ----- hw/rtl/chlcd_out_stage.sv -----
// Output register of the LCD sequencer: holds one beat until it is taken.
// Depends on chlcd_pkg, chlcd_ifs and the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_sequencer_macros.svh"

module chlcd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  chlcd_pkg::t_beat    i_beat,
    output logic                o_space,
    chlcd_res_if.source         o_res
);

    logic             r_valid;
    logic             n_valid;
    chlcd_pkg::t_beat r_beat;

    // Room for a new beat when empty or when the held one leaves now
    assign o_space = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.pre_delay_ms  = r_beat.pre_delay_ms;
    assign o_res.port_byte     = r_beat.port_byte;
    assign o_res.post_delay_ms = r_beat.post_delay_ms;
    assign o_res.last          = r_beat.last;

    `CHLCD_ASSERT(a_load_needs_space, i_load |-> o_space, "beat loaded over a held beat")
    `CHLCD_ASSERT(a_load_shows, i_load |=> r_valid, "loaded beat not presented")
    `CHLCD_ASSERT(a_held_beat_stable, r_valid && !o_res.ready |=> r_valid && $stable(r_beat), "held beat changed")

endmodule

// ----- verif/tb_char_lcd_nibble_sequencer.sv -----
// Self-checking bench for char_lcd_nibble_sequencer: directed table, then random operations.
// Depends on chlcd_pkg, chlcd_ifs and the RTL; expected port writes come from a local predictor.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer;

    // Op codes the block leaves alone
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    // LCD commands and nibbles of the power-on program
    localparam logic [3:0] WAKE_NIB      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB  = 4'h2;
    localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
    localparam logic [7:0] LCD_DISP_OFF  = 8'h08;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [2:0] SETTLE_MS     = 3'd1;
    localparam logic [2:0] WAKE_FIRST_MS = 3'd5;
    localparam logic [2:0] WAKE_NEXT_MS  = 3'd1;

    // Run shape
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 14;
    localparam int N_RANDOM     = 340;
    localparam int PHASE_LEN    = 40;
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_AT_A   = 200;
    localparam int DRAIN_AT_B   = 300;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_CAP   = 100;
    localparam int N_DIRECTED   = 20;

    // One operation beat, with an optional typed-in expectation
    typedef struct {
        logic [2:0] op;
        logic [7:0] value;
        logic       row;
        logic [5:0] column;
        bit         pinned;
        logic [7:0] first_port;
        logic [2:0] last_post;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    chlcd_op_if  op_ch ();
    chlcd_res_if res_ch ();

    char_lcd_nibble_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch),
        .o_res   (res_ch)
    );

    // Scoreboard state
    chlcd_pkg::t_beat expected_writes [$];
    chlcd_pkg::t_beat op_writes [$];
    t_stim_row        pin_marks [$];
    int               n_mismatch  = 0;
    int               n_writes    = 0;
    int               n_holds     = 0;
    int               n_drains    = 0;
    int               idle_cycles = 0;
    int               n_ops [8];
    bit               calm        = 1'b0;
    bit               hold_req    = 1'b0;

    // Directed rows: extremes, every op, ignored fields, spare op codes
    t_stim_row dir_rows [N_DIRECTED] = '{
        '{chlcd_pkg::OP_INIT,   8'h00, 1'b0, 6'd0,  1'b1, 8'h38, 3'd1},
        '{chlcd_pkg::OP_CMD,    8'h00, 1'b0, 6'd0,  1'b1, 8'h08, 3'd1},
        '{chlcd_pkg::OP_CMD,    8'hFF, 1'b0, 6'd0,  1'b1, 8'hF8, 3'd1},
        '{chlcd_pkg::OP_DATA,   8'h00, 1'b0, 6'd0,  1'b1, 8'h09, 3'd1},
        '{chlcd_pkg::OP_DATA,   8'hFF, 1'b0, 6'd0,  1'b1, 8'hF9, 3'd1},
        '{chlcd_pkg::OP_CURSOR, 8'h00, 1'b0, 6'd0,  1'b1, 8'h88, 3'd1},
        '{chlcd_pkg::OP_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, 8'hF8, 3'd1},
        '{chlcd_pkg::OP_CURSOR, 8'hFF, 1'b0, 6'd63, 1'b1, 8'hB8, 3'd1},
        '{chlcd_pkg::OP_CURSOR, 8'hFF, 1'b1, 6'd0,  1'b1, 8'hC8, 3'd1},
        '{chlcd_pkg::OP_CLEAR,  8'h00, 1'b0, 6'd0,  1'b1, 8'h08, 3'd3},
        '{OP_RSVD_A,            8'hFF, 1'b1, 6'd63, 1'b0, 8'h00, 3'd0},
        '{chlcd_pkg::OP_CMD,    8'h01, 1'b0, 6'd0,  1'b1, 8'h08, 3'd1},
        '{OP_RSVD_B,            8'h00, 1'b0, 6'd0,  1'b0, 8'h00, 3'd0},
        '{chlcd_pkg::OP_CLEAR,  8'hFF, 1'b1, 6'd63, 1'b1, 8'h08, 3'd3},
        '{OP_RSVD_C,            8'h5A, 1'b1, 6'd42, 1'b0, 8'h00, 3'd0},
        '{chlcd_pkg::OP_INIT,   8'hAA, 1'b1, 6'd21, 1'b1, 8'h38, 3'd1},
        '{chlcd_pkg::OP_DATA,   8'hA5, 1'b1, 6'd42, 1'b0, 8'h00, 3'd0},
        '{chlcd_pkg::OP_CMD,    8'h5A, 1'b1, 6'd7,  1'b0, 8'h00, 3'd0},
        '{chlcd_pkg::OP_CURSOR, 8'hC3, 1'b1, 6'd21, 1'b0, 8'h00, 3'd0},
        '{chlcd_pkg::OP_DATA,   8'h3C, 1'b0, 6'd0,  1'b0, 8'h00, 3'd0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Three writes for one nibble: plain, enable high, enable low
    function automatic void nibble_writes(input logic [3:0] nib, input logic rs,
                                          input logic [5:0] pre, input logic [2:0] extra_ms);
        chlcd_pkg::t_beat b;
        logic [7:0]       port;
        port = {nib, 4'h0} | chlcd_pkg::BIT_BL | (rs ? chlcd_pkg::BIT_RS : 8'h00);
        b.pre_delay_ms  = pre;
        b.port_byte     = port;
        b.post_delay_ms = 3'd0;
        b.last          = 1'b0;
        op_writes.push_back(b);
        b.pre_delay_ms  = 6'd0;
        b.port_byte     = port | chlcd_pkg::BIT_EN;
        b.post_delay_ms = SETTLE_MS;
        op_writes.push_back(b);
        b.port_byte     = port & ~chlcd_pkg::BIT_EN;
        b.post_delay_ms = SETTLE_MS + extra_ms;
        op_writes.push_back(b);
    endfunction

    // A whole byte: high nibble first
    function automatic void byte_writes(input logic [7:0] v, input logic rs,
                                        input logic [2:0] extra_ms);
        nibble_writes(v[7:4], rs, 6'd0, 3'd0);
        nibble_writes(v[3:0], rs, 6'd0, extra_ms);
    endfunction

    // Expected port writes of one operation, left in op_writes
    function automatic void predict_port_writes(input t_stim_row it);
        chlcd_pkg::t_beat b;
        logic [7:0]       addr;
        op_writes.delete();
        case (it.op)
            chlcd_pkg::OP_CMD:    byte_writes(it.value, 1'b0, 3'd0);
            chlcd_pkg::OP_DATA:   byte_writes(it.value, 1'b1, 3'd0);
            chlcd_pkg::OP_CURSOR: begin
                addr = (it.row ? chlcd_pkg::ROW1_BASE : chlcd_pkg::ROW0_BASE)
                       + {2'b00, it.column};
                byte_writes(addr, 1'b0, 3'd0);
            end
            chlcd_pkg::OP_CLEAR:
                byte_writes(chlcd_pkg::CMD_CLEAR, 1'b0, {1'b0, chlcd_pkg::CLEAR_WAIT});
            chlcd_pkg::OP_INIT: begin
                nibble_writes(WAKE_NIB, 1'b0, chlcd_pkg::POWER_MS, WAKE_FIRST_MS);
                nibble_writes(WAKE_NIB, 1'b0, 6'd0, WAKE_NEXT_MS);
                nibble_writes(WAKE_NIB, 1'b0, 6'd0, 3'd0);
                nibble_writes(FOUR_BIT_NIB, 1'b0, 6'd0, 3'd0);
                byte_writes(LCD_FUNC_SET, 1'b0, 3'd0);
                byte_writes(LCD_DISP_OFF, 1'b0, 3'd0);
                byte_writes(chlcd_pkg::CMD_CLEAR, 1'b0, {1'b0, chlcd_pkg::CLEAR_WAIT});
                byte_writes(LCD_ENTRY, 1'b0, 3'd0);
                byte_writes(LCD_DISP_ON, 1'b0, 3'd0);
            end
            default: ;
        endcase
        if (op_writes.size() != 0) begin
            b = op_writes.pop_back();
            b.last = 1'b1;
            op_writes.push_back(b);
        end
    endfunction

    function automatic t_stim_row random_op_row();
        t_stim_row   r;
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        r.value      = 8'($urandom_range(0, 255));
        r.row        = 1'($urandom_range(0, 1));
        r.column     = 6'($urandom_range(0, 63));
        r.pinned     = 1'b0;
        r.first_port = 8'h00;
        r.last_post  = 3'd0;
        if (pick < 30)      r.op = chlcd_pkg::OP_DATA;
        else if (pick < 55) r.op = chlcd_pkg::OP_CMD;
        else if (pick < 75) r.op = chlcd_pkg::OP_CURSOR;
        else if (pick < 87) r.op = chlcd_pkg::OP_CLEAR;
        else if (pick < 94) r.op = chlcd_pkg::OP_INIT;
        else begin
            case ($urandom_range(0, 2))
                0:       r.op = OP_RSVD_A;
                1:       r.op = OP_RSVD_B;
                default: r.op = OP_RSVD_C;
            endcase
        end
        return r;
    endfunction

    // Offer one operation beat after a random gap; returns at the accepting edge
    task automatic send_item(input t_stim_row r);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid  <= 1'b1;
        op_ch.op     <= r.op;
        op_ch.value  <= r.value;
        op_ch.row    <= r.row;
        op_ch.column <= r.column;
        pin_marks.push_back(r);
        do @(posedge i_clk); while (!(op_ch.valid && op_ch.ready));
    endtask

    // Stop offering until every expected write is out
    task automatic drain_results();
        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_writes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_drains++;
    endtask

    // Stimulus and end of run
    initial begin : stimulus
        t_stim_row r;
        int        idx;
        int        n_useful;
        i_rst_n      <= 1'b0;
        op_ch.valid  <= 1'b0;
        op_ch.op     <= chlcd_pkg::OP_CMD;
        op_ch.value  <= 8'h00;
        op_ch.row    <= 1'b0;
        op_ch.column <= 6'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_item(dir_rows[k]);
        drain_results();

        // random part in phases, some without any idling
        idx      = 0;
        n_useful = 0;
        while (n_useful < N_RANDOM) begin
            if (idx % PHASE_LEN == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (idx == HOLD_AT) begin
                // sender keeps pushing while the output side stalls
                calm     = 1'b1;
                hold_req = 1'b1;
            end
            if (idx == DRAIN_AT_A || idx == DRAIN_AT_B)
                drain_results();
            r = random_op_row();
            if (r.op <= chlcd_pkg::OP_INIT)
                n_useful++;
            send_item(r);
            idx++;
        end

        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_writes.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d operations: %0d command, %0d data, %0d cursor, %0d clear,",
                 n_ops[chlcd_pkg::OP_CMD] + n_ops[chlcd_pkg::OP_DATA]
                 + n_ops[chlcd_pkg::OP_CURSOR] + n_ops[chlcd_pkg::OP_CLEAR]
                 + n_ops[chlcd_pkg::OP_INIT] + n_ops[OP_RSVD_A] + n_ops[OP_RSVD_B]
                 + n_ops[OP_RSVD_C],
                 n_ops[chlcd_pkg::OP_CMD], n_ops[chlcd_pkg::OP_DATA],
                 n_ops[chlcd_pkg::OP_CURSOR], n_ops[chlcd_pkg::OP_CLEAR]);
        $display("  %0d init, %0d spare; %0d port writes, %0d long stall, %0d drains, %0d bad.",
                 n_ops[chlcd_pkg::OP_INIT],
                 n_ops[OP_RSVD_A] + n_ops[OP_RSVD_B] + n_ops[OP_RSVD_C],
                 n_writes, n_holds, n_drains, n_mismatch);
        if (n_mismatch == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Output side: random ready gaps, one long hold when asked
    initial begin : write_sink
        int unsigned gap;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
                n_holds++;
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // Predict on each accepted op beat, compare each accepted write beat
    always @(posedge i_clk) begin : check_port_writes
        t_stim_row        acc;
        t_stim_row        mark;
        chlcd_pkg::t_beat b;
        chlcd_pkg::t_beat got;
        chlcd_pkg::t_beat want;
        if (i_rst_n) begin
            if (op_ch.valid && op_ch.ready) begin
                acc.op     = op_ch.op;
                acc.value  = op_ch.value;
                acc.row    = op_ch.row;
                acc.column = op_ch.column;
                mark       = pin_marks.pop_front();
                predict_port_writes(acc);
                // typed-in expectations replace the predicted first byte and final wait
                if (mark.pinned && op_writes.size() != 0) begin
                    b = op_writes.pop_front();
                    b.port_byte = mark.first_port;
                    op_writes.push_front(b);
                    b = op_writes.pop_back();
                    b.post_delay_ms = mark.last_post;
                    op_writes.push_back(b);
                end
                while (op_writes.size() != 0)
                    expected_writes.push_back(op_writes.pop_front());
                n_ops[acc.op]++;
            end
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.pre_delay_ms, res_ch.port_byte, res_ch.post_delay_ms, res_ch.last};
                if (expected_writes.size() == 0) begin
                    flag_mismatch($sformatf("write %0d unexpected, port %02h",
                                            n_writes, got.port_byte));
                end else begin
                    want = expected_writes.pop_front();
                    if (got.pre_delay_ms !== want.pre_delay_ms)
                        flag_mismatch($sformatf("write %0d pre_delay_ms %0d, want %0d",
                                                n_writes, got.pre_delay_ms, want.pre_delay_ms));
                    if (got.port_byte !== want.port_byte)
                        flag_mismatch($sformatf("write %0d port_byte %02h, want %02h",
                                                n_writes, got.port_byte, want.port_byte));
                    if (got.post_delay_ms !== want.post_delay_ms)
                        flag_mismatch($sformatf("write %0d post_delay_ms %0d, want %0d",
                                                n_writes, got.post_delay_ms, want.post_delay_ms));
                    if (got.last !== want.last)
                        flag_mismatch($sformatf("write %0d last %b, want %b",
                                                n_writes, got.last, want.last));
                end
                n_writes++;
            end
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d writes still owed",
                     $time, idle_cycles, expected_writes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
